### src/jts_pkg.sv
// ----------------------------------------------------------------------------
// jts_pkg
// Types, character codes and keyword tables shared by the JSON token scanner.
// ----------------------------------------------------------------------------
package jts_pkg;

    localparam int OFFSET_BITS = 32;
    localparam int TOKEN_BITS  = 32;
    localparam int MAX_TOKENS  = 3;
    localparam int QUEUE_DEPTH = 4;

    typedef logic [OFFSET_BITS-1:0] off_t;
    typedef logic [TOKEN_BITS-1:0]  tok_word_t;

    typedef enum logic [3:0] {
        KIND_NULL    = 4'd0,
        KIND_TRUE    = 4'd1,
        KIND_FALSE   = 4'd2,
        KIND_INTEGER = 4'd3,
        KIND_DOUBLE  = 4'd4,
        KIND_STRING  = 4'd5,
        KIND_COMMA   = 4'd6,
        KIND_COLON   = 4'd7,
        KIND_LBRACK  = 4'd8,
        KIND_RBRACK  = 4'd9,
        KIND_LBRACE  = 4'd10,
        KIND_RBRACE  = 4'd11,
        KIND_ERROR   = 4'd12,
        KIND_END     = 4'd13
    } kind_t;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_STRING  = 2'd1,
        MODE_KEYWORD = 2'd2,
        MODE_NUMBER  = 2'd3
    } mode_t;

    // class of the last number byte
    typedef enum logic [1:0] {
        PK_DIGIT = 2'd0,
        PK_DOT   = 2'd1,
        PK_EXP   = 2'd2,
        PK_MINUS = 2'd3
    } pk_t;

    localparam logic [1:0] KW_NULL  = 2'd0;
    localparam logic [1:0] KW_TRUE  = 2'd1;
    localparam logic [1:0] KW_FALSE = 2'd2;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_E   = 8'h65;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_LO_L   = 8'h6C;
    localparam logic [7:0] CH_LO_N   = 8'h6E;
    localparam logic [7:0] CH_LO_R   = 8'h72;
    localparam logic [7:0] CH_LO_S   = 8'h73;
    localparam logic [7:0] CH_LO_T   = 8'h74;
    localparam logic [7:0] CH_LO_U   = 8'h75;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_E   = 8'h45;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;

    typedef struct packed {
        mode_t       mode;
        logic [1:0]  kw_choice;
        logic [2:0]  matched;
        logic        seen_dot;
        logic        seen_exp;
        logic        lead_zero;
        pk_t         prev_kind;
        logic        sign_ok;
        off_t        start_off;
        off_t        cur_off;
        logic        halted;
    } state_t;

    localparam state_t STATE_RESET = '{
        mode:      MODE_IDLE,
        kw_choice: 2'd0,
        matched:   3'd0,
        seen_dot:  1'b0,
        seen_exp:  1'b0,
        lead_zero: 1'b0,
        prev_kind: PK_DIGIT,
        sign_ok:   1'b0,
        start_off: '0,
        cur_off:   '0,
        halted:    1'b0
    };

    typedef struct packed {
        kind_t     kind;
        tok_word_t start;
        tok_word_t length;
        logic      last;
    } token_t;

    // group pushed from the scanner into the result queue
    typedef struct packed {
        logic [1:0]                  count;
        token_t [MAX_TOKENS-1:0]     tokens;
    } push_t;

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SPACE) || (b == CH_LF) || (b == CH_TAB) || (b == CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic is_alnum(input logic [7:0] b);
        return is_digit(b) || ((b >= CH_LO_A) && (b <= CH_LO_Z))
            || ((b >= CH_UP_A) && (b <= CH_UP_Z));
    endfunction

    function automatic logic [2:0] kw_len(input logic [1:0] choice);
        logic [2:0] len;
        case (choice)
            KW_NULL:  len = 3'd4;
            KW_TRUE:  len = 3'd4;
            KW_FALSE: len = 3'd5;
            default:  len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] kw_char(input logic [1:0] choice, input logic [2:0] idx);
        logic [7:0] c;
        case ({choice, idx})
            {KW_NULL, 3'd0}:  c = CH_LO_N;
            {KW_NULL, 3'd1}:  c = CH_LO_U;
            {KW_NULL, 3'd2}:  c = CH_LO_L;
            {KW_NULL, 3'd3}:  c = CH_LO_L;
            {KW_TRUE, 3'd0}:  c = CH_LO_T;
            {KW_TRUE, 3'd1}:  c = CH_LO_R;
            {KW_TRUE, 3'd2}:  c = CH_LO_U;
            {KW_TRUE, 3'd3}:  c = CH_LO_E;
            {KW_FALSE, 3'd0}: c = CH_LO_F;
            {KW_FALSE, 3'd1}: c = CH_LO_A;
            {KW_FALSE, 3'd2}: c = CH_LO_L;
            {KW_FALSE, 3'd3}: c = CH_LO_S;
            {KW_FALSE, 3'd4}: c = CH_LO_E;
            default:          c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic token_t mk_tok(input kind_t kind, input off_t start, input off_t len);
        token_t t;
        t.kind   = kind;
        t.start  = TOKEN_BITS'(start);
        t.length = TOKEN_BITS'(len);
        t.last   = 1'b0;
        return t;
    endfunction

endpackage

### src/jts_byte_if.sv
// ----------------------------------------------------------------------------
// jts_byte_if
// Valid/ready channel carrying one byte of JSON text per item.
// ----------------------------------------------------------------------------
interface jts_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       end_of_input;

    modport source (output valid, output byte_value, output end_of_input, input ready);
    modport sink   (input valid, input byte_value, input end_of_input, output ready);
endinterface

### src/jts_token_if.sv
// ----------------------------------------------------------------------------
// jts_token_if
// Valid/ready channel carrying one token per item.
// ----------------------------------------------------------------------------
interface jts_token_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [31:0] token_start;
    logic [31:0] token_length;
    logic        last_of_run;

    modport source (output valid, output token_kind, output token_start,
                    output token_length, output last_of_run, input ready);
    modport sink   (input valid, input token_kind, input token_start,
                    input token_length, input last_of_run, output ready);
endinterface

### src/jts_step.sv
// ----------------------------------------------------------------------------
// jts_step
// Scanner step: next state and up to three tokens for one byte.
// ----------------------------------------------------------------------------
module jts_step
    import jts_pkg::*;
(
    input  state_t      state,
    input  logic [7:0]  byte_value,
    input  logic        end_of_input,
    output state_t      state_next,
    output push_t       push
);

    always_comb
    begin
        state_t                  ns;
        token_t [MAX_TOKENS-1:0] tk;
        logic [1:0]              n;
        logic                    do_start;
        off_t                    cur;
        off_t                    nxt;
        logic [1:0]              ch;
        logic [2:0]              klen;
        logic [7:0]              b;

        ns       = state;
        tk       = '0;
        n        = 2'd0;
        do_start = 1'b0;
        b        = byte_value;
        cur      = state.cur_off;
        nxt      = off_t'(state.cur_off + 1'b1);
        ch       = state.kw_choice;
        klen     = kw_len(state.kw_choice);

        if (!state.halted)
        begin
            case (state.mode)
                MODE_STRING:
                begin
                    if (b == CH_QUOTE)
                    begin
                        tk[n] = mk_tok(KIND_STRING, state.start_off,
                                       off_t'(cur - state.start_off));
                        n = n + 2'd1;
                        ns.mode = MODE_IDLE;
                    end
                end
                MODE_KEYWORD:
                begin
                    if (state.matched < klen)
                    begin
                        if (b == kw_char(ch, state.matched))
                        begin
                            ns.matched = state.matched + 3'd1;
                        end
                        else
                        begin
                            tk[n] = mk_tok(KIND_ERROR, state.start_off,
                                           off_t'(cur - state.start_off + 1'b1));
                            n = n + 2'd1;
                            ns.halted = 1'b1;
                            ns.mode = MODE_IDLE;
                        end
                    end
                    else if (is_alnum(b))
                    begin
                        tk[n] = mk_tok(KIND_ERROR, state.start_off,
                                       off_t'(cur - state.start_off + 1'b1));
                        n = n + 2'd1;
                        ns.halted = 1'b1;
                        ns.mode = MODE_IDLE;
                    end
                    else
                    begin
                        tk[n] = mk_tok(kind_t'({2'b00, ch}), state.start_off, off_t'(klen));
                        n = n + 2'd1;
                        ns.mode = MODE_IDLE;
                        do_start = 1'b1;
                    end
                end
                MODE_NUMBER:
                begin
                    if (state.sign_ok && ((b == CH_PLUS) || (b == CH_MINUS)))
                    begin
                        ns.sign_ok = 1'b0;
                        ns.prev_kind = PK_EXP;
                    end
                    else
                    begin
                        ns.sign_ok = 1'b0;
                        if (b == CH_DOT)
                        begin
                            if (state.seen_dot || state.seen_exp)
                            begin
                                tk[n] = mk_tok(KIND_ERROR, state.start_off,
                                               off_t'(cur - state.start_off + 1'b1));
                                n = n + 2'd1;
                                ns.halted = 1'b1;
                                ns.mode = MODE_IDLE;
                            end
                            else
                            begin
                                ns.seen_dot = 1'b1;
                                ns.prev_kind = PK_DOT;
                            end
                        end
                        else if (is_digit(b))
                        begin
                            if (state.lead_zero && !state.seen_exp && !state.seen_dot)
                            begin
                                tk[n] = mk_tok(KIND_ERROR, state.start_off,
                                               off_t'(cur - state.start_off + 1'b1));
                                n = n + 2'd1;
                                ns.halted = 1'b1;
                                ns.mode = MODE_IDLE;
                            end
                            else
                            begin
                                // a zero right after the minus is a leading zero too
                                if ((state.prev_kind == PK_MINUS) && (b == CH_ZERO))
                                begin
                                    ns.lead_zero = 1'b1;
                                end
                                ns.prev_kind = PK_DIGIT;
                            end
                        end
                        else if ((b == CH_LO_E) || (b == CH_UP_E))
                        begin
                            if ((state.prev_kind == PK_DOT) || state.seen_exp)
                            begin
                                tk[n] = mk_tok(KIND_ERROR, state.start_off,
                                               off_t'(cur - state.start_off + 1'b1));
                                n = n + 2'd1;
                                ns.halted = 1'b1;
                                ns.mode = MODE_IDLE;
                            end
                            else
                            begin
                                ns.seen_exp = 1'b1;
                                ns.sign_ok = 1'b1;
                                ns.prev_kind = PK_EXP;
                            end
                        end
                        else if (is_ws(b) || (b inside {CH_COMMA, CH_RBRACK, CH_RBRACE}))
                        begin
                            if (state.prev_kind != PK_DIGIT)
                            begin
                                tk[n] = mk_tok(KIND_ERROR, state.start_off,
                                               off_t'(cur - state.start_off + 1'b1));
                                n = n + 2'd1;
                                ns.halted = 1'b1;
                                ns.mode = MODE_IDLE;
                            end
                            else
                            begin
                                tk[n] = mk_tok((state.seen_dot || state.seen_exp) ?
                                               KIND_DOUBLE : KIND_INTEGER,
                                               state.start_off,
                                               off_t'(cur - state.start_off));
                                n = n + 2'd1;
                                ns.mode = MODE_IDLE;
                                do_start = 1'b1;
                            end
                        end
                        else
                        begin
                            tk[n] = mk_tok(KIND_ERROR, state.start_off,
                                           off_t'(cur - state.start_off + 1'b1));
                            n = n + 2'd1;
                            ns.halted = 1'b1;
                            ns.mode = MODE_IDLE;
                        end
                    end
                end
                default:
                begin
                    do_start = 1'b1;
                end
            endcase
        end

        // tokenize a byte seen between tokens, including a terminator
        if (do_start && !is_ws(b))
        begin
            case (b)
                CH_COMMA:
                begin
                    tk[n] = mk_tok(KIND_COMMA, cur, off_t'(1));
                    n = n + 2'd1;
                end
                CH_COLON:
                begin
                    tk[n] = mk_tok(KIND_COLON, cur, off_t'(1));
                    n = n + 2'd1;
                end
                CH_LBRACK:
                begin
                    tk[n] = mk_tok(KIND_LBRACK, cur, off_t'(1));
                    n = n + 2'd1;
                end
                CH_RBRACK:
                begin
                    tk[n] = mk_tok(KIND_RBRACK, cur, off_t'(1));
                    n = n + 2'd1;
                end
                CH_LBRACE:
                begin
                    tk[n] = mk_tok(KIND_LBRACE, cur, off_t'(1));
                    n = n + 2'd1;
                end
                CH_RBRACE:
                begin
                    tk[n] = mk_tok(KIND_RBRACE, cur, off_t'(1));
                    n = n + 2'd1;
                end
                CH_QUOTE:
                begin
                    ns.mode = MODE_STRING;
                    ns.start_off = nxt;
                end
                CH_LO_N, CH_LO_T, CH_LO_F:
                begin
                    ns.mode = MODE_KEYWORD;
                    ns.kw_choice = (b == CH_LO_N) ? KW_NULL :
                                   (b == CH_LO_T) ? KW_TRUE : KW_FALSE;
                    ns.matched = 3'd1;
                    ns.start_off = cur;
                end
                default:
                begin
                    if (is_digit(b) || (b == CH_MINUS))
                    begin
                        ns.mode = MODE_NUMBER;
                        ns.start_off = cur;
                        ns.seen_dot = 1'b0;
                        ns.seen_exp = 1'b0;
                        ns.sign_ok = 1'b0;
                        ns.lead_zero = (b == CH_ZERO);
                        ns.prev_kind = (b == CH_MINUS) ? PK_MINUS : PK_DIGIT;
                    end
                    else
                    begin
                        tk[n] = mk_tok(KIND_ERROR, cur, off_t'(1));
                        n = n + 2'd1;
                        ns.halted = 1'b1;
                        ns.mode = MODE_IDLE;
                    end
                end
            endcase
        end

        if (end_of_input)
        begin
            // close an open token, then mark the end of the text
            if (!ns.halted)
            begin
                case (ns.mode)
                    MODE_STRING:
                    begin
                        tk[n] = mk_tok(KIND_STRING, ns.start_off, off_t'(nxt - ns.start_off));
                        n = n + 2'd1;
                    end
                    MODE_KEYWORD:
                    begin
                        if (ns.matched == klen)
                        begin
                            tk[n] = mk_tok(kind_t'({2'b00, ch}), ns.start_off, off_t'(klen));
                        end
                        else
                        begin
                            tk[n] = mk_tok(KIND_ERROR, ns.start_off,
                                           off_t'(cur - ns.start_off + 1'b1));
                        end
                        n = n + 2'd1;
                    end
                    MODE_NUMBER:
                    begin
                        if (ns.prev_kind == PK_DIGIT)
                        begin
                            tk[n] = mk_tok((ns.seen_dot || ns.seen_exp) ?
                                           KIND_DOUBLE : KIND_INTEGER,
                                           ns.start_off, off_t'(nxt - ns.start_off));
                        end
                        else
                        begin
                            tk[n] = mk_tok(KIND_ERROR, ns.start_off,
                                           off_t'(cur - ns.start_off + 1'b1));
                        end
                        n = n + 2'd1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            tk[n] = mk_tok(KIND_END, nxt, off_t'(0));
            n = n + 2'd1;
            ns = STATE_RESET;
        end
        else
        begin
            ns.cur_off = nxt;
        end

        for (int i = 0; i < MAX_TOKENS; i++)
        begin
            tk[i].last = (2'(i + 1) == n);
        end

        state_next  = ns;
        push.count  = n;
        push.tokens = tk;
    end

endmodule

### src/jts_token_queue.sv
// ----------------------------------------------------------------------------
// jts_token_queue
// Small result queue: takes up to three tokens a cycle, hands out one.
// ----------------------------------------------------------------------------
module jts_token_queue
    import jts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  push_t             push,
    output logic              room,
    jts_token_if.source       token_out
);

    localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    token_t                mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg;
    logic [PTR_BITS-1:0]   wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg;
    logic [PTR_BITS-1:0]   rd_ptr_next;
    logic [CNT_BITS-1:0]   count_reg;
    logic [CNT_BITS-1:0]   count_next;
    logic [CNT_BITS-1:0]   after_pop;
    logic                  pop;

    assign pop       = token_out.valid && token_out.ready;
    assign after_pop = count_reg - CNT_BITS'(pop);
    // a step may push a full run of tokens
    assign room      = (CNT_BITS'(QUEUE_DEPTH) - after_pop) >= CNT_BITS'(MAX_TOKENS);

    assign wr_ptr_next = wr_ptr_reg + PTR_BITS'(push.count);
    assign rd_ptr_next = rd_ptr_reg + PTR_BITS'(pop);
    assign count_next  = after_pop + CNT_BITS'(push.count);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_TOKENS; i++)
        begin
            if (2'(i) < push.count)
            begin
                mem[wr_ptr_reg + PTR_BITS'(i)] <= push.tokens[i];
            end
        end
    end

    assign token_out.valid        = (count_reg != '0);
    assign token_out.token_kind   = mem[rd_ptr_reg].kind;
    assign token_out.token_start  = mem[rd_ptr_reg].start;
    assign token_out.token_length = mem[rd_ptr_reg].length;
    assign token_out.last_of_run  = mem[rd_ptr_reg].last;

endmodule

### src/json_token_scanner.sv
// ----------------------------------------------------------------------------
// json_token_scanner
// Streaming JSON lexer: bytes in, tokens (kind, start, length) out.
// ----------------------------------------------------------------------------
// Usage:
//   byte_in carries one byte of text per item with end_of_input marking the
//   final byte. token_out carries one token per item; last_of_run flags the
//   final token caused by a byte. Every text ends with an end token.
//   A byte is held in an input register, then the scan step updates the
//   scanner state and writes its tokens (zero to three) into a four-entry
//   result queue. A byte's tokens are written into the queue as the byte
//   leaves the input register and are offered behind any tokens still
//   waiting there.
//   Throughput is one byte per cycle while each byte gives at most one token
//   and the receiver takes one every cycle. A byte that gives three tokens
//   holds up the next byte; steady runs of multi-token bytes go at the
//   output's pace of one token per cycle.
//   When the receiver stalls, tokens wait in the queue and byte_in.ready
//   drops once there is no room for a full run of three.
//   Reset clears the state to idle at offset zero and empties the queue.
//   After end of input the offset returns to zero for the next text.
// ----------------------------------------------------------------------------
module json_token_scanner
    import jts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    jts_byte_if.sink    byte_in,
    jts_token_if.source token_out
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_eoi_reg;
    state_t     state_reg;
    state_t     state_next;
    push_t      step_push;
    push_t      queue_push;
    logic       room;
    logic       fire;

    assign fire          = in_valid_reg && room;
    assign byte_in.ready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (byte_in.ready)
        begin
            in_valid_reg <= byte_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_in.ready && byte_in.valid)
        begin
            in_byte_reg <= byte_in.byte_value;
            in_eoi_reg  <= byte_in.end_of_input;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (fire)
        begin
            state_reg <= state_next;
        end
    end

    jts_step u_step (
        .state        (state_reg),
        .byte_value   (in_byte_reg),
        .end_of_input (in_eoi_reg),
        .state_next   (state_next),
        .push         (step_push)
    );

    // push nothing unless the held byte is taken this cycle
    always_comb
    begin
        queue_push        = step_push;
        queue_push.count  = fire ? step_push.count : 2'd0;
    end

    jts_token_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (queue_push),
        .room      (room),
        .token_out (token_out)
    );

`ifndef SYNTH
    a_halted_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.halted |-> (state_reg.mode == MODE_IDLE))
        else $error("scanner halted outside idle mode");

    a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && in_eoi_reg) |=> ((state_reg.cur_off == '0) && !state_reg.halted))
        else $error("state not cleared after end of input");

    a_end_token: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && in_eoi_reg) |-> (step_push.count != 2'd0))
        else $error("end of input gave no token");

    a_offset_step: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !in_eoi_reg) |=>
            (state_reg.cur_off == off_t'($past(state_reg.cur_off) + 1'b1)))
        else $error("offset did not advance by one byte");
`endif

endmodule
